### hdl/adtn_pkg.sv
// adtn_pkg: shared widths, latency constants and the output saturation
// function for aim_direction_to_ndc. Used by every module in hdl/.
package adtn_pkg;

  localparam int COMP_W   = 16;   // Q1.14 vector component
  localparam int EXT_W    = 16;   // Q2.14 frustum extent
  localparam int COS_W    = 15;   // Q1.14 minimum cosine
  localparam int NDC_W    = 24;   // Q8.16 result
  localparam int PROD_W   = 32;   // 16x16 signed product
  localparam int DOT_W    = 34;   // sum of three products
  localparam int MAG_W    = 33;   // magnitude of a dot product
  localparam int DEN_W    = 48;   // forward dot times extent
  localparam int NUM_W    = 64;   // (mag << 30) + den/2
  localparam int FRAC_SH  = 30;
  localparam int Q_W      = 25;   // quotient bits kept, one divider stage each
  localparam int DIV_STAGES = Q_W;
  localparam int IN_W     = 12 * COMP_W;
  localparam int OUT_W    = 2 * NDC_W;

  localparam logic [1:0] REG_FRUSTUM_RIGHT = 2'd0;
  localparam logic [1:0] REG_FRUSTUM_TOP   = 2'd1;
  localparam logic [1:0] REG_MIN_COS       = 2'd2;

  // Signed, saturated Q8.16 from an unsigned rounded quotient.
  function automatic logic [NDC_W-1:0] ndc_sat(input logic [Q_W-1:0] q,
                                               input logic ovf,
                                               input logic neg);
    logic [Q_W-1:0] neg_q;
    neg_q = -q;
    if (neg) begin
      if (ovf || q > (Q_W'(1) << (NDC_W - 1))) ndc_sat = {1'b1, {(NDC_W-1){1'b0}}};
      else ndc_sat = neg_q[NDC_W-1:0];
    end else begin
      if (ovf || q > Q_W'({1'b0, {(NDC_W-1){1'b1}}})) ndc_sat = {1'b0, {(NDC_W-1){1'b1}}};
      else ndc_sat = q[NDC_W-1:0];
    end
  endfunction

endpackage

### hdl/adtn_div.sv
// adtn_div: pipelined restoring divider, one quotient bit per stage.
// Depends on adtn_pkg for widths.
module adtn_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [adtn_pkg::NUM_W-1:0]    num,
  input  logic [adtn_pkg::DEN_W-1:0]    den,
  output logic [adtn_pkg::Q_W-1:0]      q,
  output logic                          ovf
);
  localparam int DW = adtn_pkg::DEN_W;
  localparam int QW = adtn_pkg::Q_W;
  localparam int NS = adtn_pkg::DIV_STAGES;

  logic [DW-1:0] rem  [NS];
  logic [QW-1:0] low  [NS];
  logic [QW-1:0] quo  [NS];
  logic [DW-1:0] dn   [NS];
  logic          of   [NS];

  // Top bits of the dividend form the first partial remainder; if they
  // already reach the divisor the quotient does not fit.
  logic [DW-1:0] r0;
  assign r0 = DW'(num[adtn_pkg::NUM_W-1:QW]);

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DW-1:0] r_in;
    logic [QW-1:0] l_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic          o_in;
    logic [DW:0]   trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign r_in = r0;
      assign l_in = num[QW-1:0];
      assign q_in = '0;
      assign d_in = den;
      assign o_in = (r0 >= den);
    end else begin : g_next
      assign r_in = rem[k-1];
      assign l_in = low[k-1];
      assign q_in = quo[k-1];
      assign d_in = dn[k-1];
      assign o_in = of[k-1];
    end
    assign trial = {r_in, l_in[QW-1]};
    assign ge    = trial >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        low[k] <= {l_in[QW-2:0], 1'b0};
        quo[k] <= {q_in[QW-2:0], ge};
        dn[k]  <= d_in;
        of[k]  <= o_in;
      end
    end
  end

  assign q   = quo[NS-1];
  assign ovf = of[NS-1];
endmodule

### hdl/aim_direction_to_ndc.sv
// aim_direction_to_ndc: projects a reference forward direction onto a camera
// basis and outputs saturated Q8.16 device coordinates.
// Depends on adtn_pkg and adtn_div.
//
// Pipeline: four arithmetic stages, 25 divider stages and one saturation/output
// stage lie between the input transaction and the output register.
// Throughput: one transaction per cycle; the 25-stage divider pipeline per
// axis sets the depth. A stall freezes the whole pipeline.
// Reset (rst, synchronous): clears all valid bits and loads the register
// defaults (extents 1.0, minimum cosine 164).
module aim_direction_to_ndc (
  input  logic                         clk,
  input  logic                         rst,
  // ref_fwd_x/y/z, cam_fwd_x/y/z, cam_up_x/y/z, cam_right_x/y/z, 16 bits each
  input  logic [adtn_pkg::IN_W-1:0]    s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // ndc_x [23:0], ndc_y [47:24]
  output logic [adtn_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tuser,   // valid_res
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [adtn_pkg::EXT_W-1:0]   cfg_data
);
  localparam int CW = adtn_pkg::COMP_W;
  localparam int PW = adtn_pkg::PROD_W;
  localparam int DTW = adtn_pkg::DOT_W;
  localparam int MW = adtn_pkg::MAG_W;
  localparam int DW = adtn_pkg::DEN_W;
  localparam int NW = adtn_pkg::NUM_W;
  localparam int NS = adtn_pkg::DIV_STAGES;

  // ---------------- configuration registers ----------------
  logic [adtn_pkg::EXT_W-1:0] frustum_right, frustum_top;
  logic [adtn_pkg::COS_W-1:0] min_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      frustum_right <= 16'd16384;
      frustum_top   <= 16'd16384;
      min_cos       <= 15'd164;
    end else if (cfg_we) begin
      case (cfg_addr)
        adtn_pkg::REG_FRUSTUM_RIGHT: frustum_right <= cfg_data;
        adtn_pkg::REG_FRUSTUM_TOP:   frustum_top   <= cfg_data;
        adtn_pkg::REG_MIN_COS:       min_cos       <= cfg_data[adtn_pkg::COS_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the output holds an untaken transaction.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: nine products ----------------
  logic signed [CW-1:0] comp [12];
  for (genvar i = 0; i < 12; i++) begin : g_unpack
    assign comp[i] = s_tdata[i*CW +: CW];
  end

  logic            v1;
  logic signed [PW-1:0] p_fwd [3], p_up [3], p_rt [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        p_fwd[j] <= comp[j] * comp[3+j];
        p_up[j]  <= comp[j] * comp[6+j];
        p_rt[j]  <= comp[j] * comp[9+j];
      end
    end
  end

  // ---------------- stage 2: dot sums and acceptance test ----------------
  logic                  v2;
  logic signed [DTW-1:0] d_fwd, d_up, d_rt;
  always_ff @(posedge clk) begin
    if (en) begin
      d_fwd <= DTW'(p_fwd[0]) + DTW'(p_fwd[1]) + DTW'(p_fwd[2]);
      d_up  <= DTW'(p_up[0])  + DTW'(p_up[1])  + DTW'(p_up[2]);
      d_rt  <= DTW'(p_rt[0])  + DTW'(p_rt[1])  + DTW'(p_rt[2]);
    end
  end

  // ---------------- stage 3: denominators, magnitudes ----------------
  logic signed [DTW-1:0] thresh;
  logic                  ok2;
  assign thresh = DTW'({min_cos, 14'b0});
  assign ok2    = (d_fwd > thresh) && (frustum_right != '0) && (frustum_top != '0);

  logic          v3, ok3, neg_x3, neg_y3;
  logic [DW-1:0] den_x3, den_y3;
  logic [MW-1:0] mag_x3, mag_y3;
  always_ff @(posedge clk) begin
    if (en) begin
      // d_fwd is positive whenever ok holds, so its low 32 bits suffice.
      den_x3 <= d_fwd[31:0] * frustum_right;
      den_y3 <= d_fwd[31:0] * frustum_top;
      neg_x3 <= d_rt[DTW-1];
      neg_y3 <= d_up[DTW-1];
      mag_x3 <= d_rt[DTW-1] ? MW'(-d_rt) : MW'(d_rt);
      mag_y3 <= d_up[DTW-1] ? MW'(-d_up) : MW'(d_up);
      ok3    <= ok2;
    end
  end

  // ---------------- stage 4: rounded dividends ----------------
  logic          v4, ok4, neg_x4, neg_y4;
  logic [NW-1:0] num_x4, num_y4;
  logic [DW-1:0] den_x4, den_y4;
  always_ff @(posedge clk) begin
    if (en) begin
      num_x4 <= NW'({mag_x3, {adtn_pkg::FRAC_SH{1'b0}}}) + NW'(den_x3 >> 1);
      num_y4 <= NW'({mag_y3, {adtn_pkg::FRAC_SH{1'b0}}}) + NW'(den_y3 >> 1);
      den_x4 <= den_x3;
      den_y4 <= den_y3;
      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
      ok4    <= ok3;
    end
  end

  // ---------------- divider pipelines ----------------
  logic [adtn_pkg::Q_W-1:0] q_x, q_y;
  logic                     ovf_x, ovf_y;

  adtn_div u_div_x (.clk, .en, .num(num_x4), .den(den_x4), .q(q_x), .ovf(ovf_x));
  adtn_div u_div_y (.clk, .en, .num(num_y4), .den(den_y4), .q(q_y), .ovf(ovf_y));

  // Sideband riding alongside the divider stages.
  logic sv [NS], sok [NS], snx [NS], sny [NS];
  always_ff @(posedge clk) begin
    if (en) begin
      sok[0] <= ok4;
      snx[0] <= neg_x4;
      sny[0] <= neg_y4;
      for (int k = 1; k < NS; k++) begin
        sok[k] <= sok[k-1];
        snx[k] <= snx[k-1];
        sny[k] <= sny[k-1];
      end
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      for (int k = 0; k < NS; k++) sv[k] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      sv[0] <= v4;
      for (int k = 1; k < NS; k++) sv[k] <= sv[k-1];
      m_tvalid <= sv[NS-1];
    end
  end

  // ---------------- output register: saturate, zero when rejected ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      if (sok[NS-1]) begin
        m_tdata <= {adtn_pkg::ndc_sat(q_y, ovf_y, sny[NS-1]),
                    adtn_pkg::ndc_sat(q_x, ovf_x, snx[NS-1])};
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= sok[NS-1];
    end
  end

endmodule

### hdl/adtn_check.sv
// adtn_check: port-level assertions for aim_direction_to_ndc, bound to
// the top level below. Depends on adtn_pkg for widths.
module adtn_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [adtn_pkg::OUT_W-1:0]  m_tdata,
  input logic                        m_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready
);
  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // Rejected projections carry zero coordinates.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid result with nonzero coordinates");

  // Nothing leaves the pipe right after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  // Input is refused only while the output is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without output stall");
endmodule

bind aim_direction_to_ndc adtn_check u_adtn_check (
  .clk, .rst, .s_tvalid, .s_tready, .m_tdata, .m_tuser, .m_tvalid, .m_tready
);
